// ===== rtl/aae_pkg.sv =====
// Shared constants and types for the adaptive arithmetic encoder.
// Used by aae_div, aae_packer and the top level; depends on nothing.
`default_nettype none
package aae_pkg;

  localparam int SYM_CNT    = 257;
  localparam int CODE_W     = 32;
  localparam int CNT_W      = 16;
  localparam int ADDR_W     = 9;
  localparam int FOLLOW_W   = 8;
  localparam int MAX_OUT    = 64;
  localparam int OCNT_W     = 7;
  localparam int DIV_W      = CODE_W + 1 + CNT_W;
  localparam int DCNT_W     = 6;
  localparam int RN_W       = 6;

  localparam logic [CODE_W-1:0]   TOP_VAL    = 32'hFFFF_FFFE;
  localparam logic [CODE_W-1:0]   HALF_PT    = 32'h8000_0000;
  localparam logic [CODE_W-1:0]   QTR_1      = 32'h4000_0000;
  localparam logic [CODE_W-1:0]   QTR_3      = 32'hC000_0000;
  localparam logic [CNT_W-1:0]    MAX_TOT_RST = 16'h8000;
  localparam logic [ADDR_W-1:0]   LAST_IDX   = 9'd257;
  localparam logic [FOLLOW_W-1:0] FOLLOW_MAX = 8'd255;
  localparam logic [RN_W-1:0]     RN_LIMIT   = 6'd32;

  typedef enum logic [2:0] {
    PK_NOP    = 3'd0,
    PK_PUT    = 3'd1,
    PK_FLUSH  = 3'd2,
    PK_FINISH = 3'd3,
    PK_CLEAR  = 3'd4
  } pk_op_t;

  typedef struct packed {
    pk_op_t op;
    logic   bit_val;
    logic   ovf;
  } pk_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/aae_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module aae_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 258,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/aae_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on aae_pkg for widths.
`default_nettype none
module aae_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [aae_pkg::DIV_W-1:0]  dividend,
  input  wire logic [aae_pkg::CNT_W-1:0]  divisor,
  output logic                            done,
  output logic      [aae_pkg::DIV_W-1:0]  quotient
);
  import aae_pkg::*;

  logic [DIV_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dsr_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    trial;
  logic              qbit;
  logic [CNT_W:0]    diff;

  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]};
    diff  = trial - {1'b0, dsr_r};
    qbit  = (trial >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
        cnt_r  <= DCNT_W'(DIV_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], qbit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/aae_packer.sv =====
// Bit packer and output stage: packs code bits LSB-first, holds the newest
// byte back so the last one of a run can be marked. Depends on aae_pkg.
`default_nettype none
module aae_packer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire aae_pkg::pk_cmd_t cmd,
  output logic                  ready,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_last_of_run,
  output logic                  out_follow_overflow
);
  import aae_pkg::*;

  logic [7:0]        pack_r;
  logic [3:0]        bits_r;
  logic [7:0]        hold_r;
  logic              hold_ovf_r;
  logic              hold_v_r;
  logic [OCNT_W-1:0] cnt_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic              out_ovf_r;

  logic       out_free;
  logic [7:0] nb;
  logic [3:0] bl;
  logic       emit;
  logic       keep;
  logic [7:0] ev;
  logic       push;
  logic       plast;
  logic       finish;

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    ready    = !hold_v_r || out_free;
    nb       = {cmd.bit_val, pack_r[7:1]};
    bl       = bits_r - 4'd1;
    emit     = 1'b0;
    ev       = nb;
    push     = 1'b0;
    plast    = 1'b0;
    finish   = 1'b0;
    case (cmd.op)
      PK_PUT: begin
        emit = (bl == 4'd0);
      end
      PK_FLUSH: begin
        emit = 1'b1;
        ev   = 8'({8'd0, pack_r} >> bits_r);
      end
      PK_FINISH: begin
        finish = 1'b1;
        push   = hold_v_r;
        plast  = 1'b1;
      end
      default: begin
      end
    endcase
    // Bytes past the per-word limit are dropped.
    keep = emit && (cnt_r < OCNT_W'(MAX_OUT));
    if (keep && hold_v_r) begin
      push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hold_v_r    <= 1'b0;
      cnt_r       <= '0;
      pack_r      <= '0;
      bits_r      <= 4'd8;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= hold_r;
        out_last_r  <= plast;
        out_ovf_r   <= hold_ovf_r;
      end
      if (keep) begin
        hold_r     <= ev;
        hold_ovf_r <= cmd.ovf;
        hold_v_r   <= 1'b1;
        cnt_r      <= cnt_r + 1'b1;
      end
      if (finish) begin
        hold_v_r <= 1'b0;
        cnt_r    <= '0;
      end
      if (cmd.op == PK_PUT) begin
        pack_r <= nb;
        bits_r <= (bl == 4'd0) ? 4'd8 : bl;
      end else if (cmd.op == PK_CLEAR) begin
        pack_r <= '0;
        bits_r <= 4'd8;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_byte            = out_byte_r;
  assign out_last_of_run     = out_last_r;
  assign out_follow_overflow = out_ovf_r;

endmodule
`default_nettype wire

// ===== rtl/adaptive_arithmetic_encoder.sv =====
// Adaptive arithmetic encoder, top level. Depends on aae_pkg, aae_ram,
// aae_div and aae_packer.
//
// Each accepted word codes one byte (or, with end_of_stream, the end symbol,
// a flush and a reset of the coder) and yields zero or more packed code
// bytes, the last marked with last_of_run. One word at a time is processed:
// three count-table reads, two divisions on the shared divider of 49
// quotient steps each, up to 32 renormalization steps, each step that emits
// a bit also passing the put and follow states that send it and its pending
// follow bits, and the model update that increments entries 0 to s-1 for
// symbol s, preceded by a halving of the counts when the total has reached
// max_total; output stalls can hold the word up further. After reset and
// after every end of stream a pass rewrites the count table, during which no
// word is taken. The max_total register may be written at any time the block
// is idle; cfg_ready is always high.
`default_nettype none
module adaptive_arithmetic_encoder (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                in_byte_in,
  input  wire logic                      in_end_of_stream,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_last_of_run,
  output logic                           out_follow_overflow,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [aae_pkg::CNT_W-1:0] cfg_max_total
);
  import aae_pkg::*;

  typedef enum logic [20:0] {
    ST_CLR   = 21'h000001,
    ST_IDLE  = 21'h000002,
    ST_RD1   = 21'h000004,
    ST_RD2   = 21'h000008,
    ST_RD3   = 21'h000010,
    ST_DIVA  = 21'h000020,
    ST_WTA   = 21'h000040,
    ST_DIVB  = 21'h000080,
    ST_WTB   = 21'h000100,
    ST_TEST  = 21'h000200,
    ST_AFT   = 21'h000400,
    ST_PUT   = 21'h000800,
    ST_FOLW  = 21'h001000,
    ST_FLUSH = 21'h002000,
    ST_ADP   = 21'h004000,
    ST_HV0   = 21'h008000,
    ST_HV1   = 21'h010000,
    ST_HVC   = 21'h020000,
    ST_INC0  = 21'h040000,
    ST_INC1  = 21'h080000,
    ST_FIN   = 21'h100000
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    max_total_r;
  logic [CODE_W-1:0]   lo_r;
  logic [CODE_W-1:0]   hi_r;
  logic [CODE_W-1:0]   hi_tmp_r;
  logic [FOLLOW_W-1:0] pend_r;
  logic                ovf_r;
  logic [ADDR_W-1:0]   sym_r;
  logic                eof_r;
  logic                final_r;
  logic                bit_r;
  logic [RN_W-1:0]     n_r;
  logic [CNT_W-1:0]    total_r;
  logic [CNT_W-1:0]    ca_r;
  logic [CNT_W-1:0]    cb_r;
  logic [DIV_W-1:0]    prod_r;
  logic [ADDR_W-1:0]   idx_r;
  logic [CNT_W-1:0]    ob_r;
  logic [CNT_W-1:0]    nbw_r;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [CNT_W-1:0]   wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [CNT_W-1:0]   rdata;
  logic               div_start;
  logic               div_done;
  logic [DIV_W-1:0]   quo;
  logic [CNT_W-1:0]   divisor;
  logic [CODE_W:0]    rng;
  logic [CNT_W-1:0]   f;
  logic [CNT_W-1:0]   hv_new;
  pk_cmd_t            pk_cmd;
  logic               pk_ready;

  aae_ram #(.WIDTH(CNT_W), .DEPTH(SYM_CNT + 1)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  aae_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo)
  );

  aae_packer u_pk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (pk_cmd),
    .ready               (pk_ready),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_last_of_run     (out_last_of_run),
    .out_follow_overflow (out_follow_overflow)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    rng       = {1'b0, hi_r - lo_r} + (CODE_W+1)'(1);
    divisor   = (total_r == '0) ? CNT_W'(1) : total_r;
    div_start = (state_r == ST_DIVA) || (state_r == ST_DIVB);
    f         = rdata - ob_r;
    hv_new    = nbw_r + CNT_W'(({1'b0, f} + 17'd1) >> 1);

    we    = 1'b0;
    waddr = idx_r;
    wdata = rdata + 1'b1;
    raddr = '0;
    unique case (state_r)
      ST_CLR: begin
        we    = 1'b1;
        wdata = CNT_W'(LAST_IDX - idx_r);
      end
      ST_RD1:  raddr = sym_r - 1'b1;
      ST_RD2:  raddr = sym_r;
      ST_HV0:  raddr = LAST_IDX;
      ST_HV1:  raddr = LAST_IDX - 1'b1;
      ST_HVC: begin
        raddr = idx_r - ADDR_W'(2);
        we    = 1'b1;
        waddr = idx_r - 1'b1;
        wdata = hv_new;
      end
      ST_INC1: begin
        raddr = idx_r + 1'b1;
        we    = 1'b1;
      end
      default: raddr = '0;
    endcase

    pk_cmd.op      = PK_NOP;
    pk_cmd.bit_val = bit_r;
    pk_cmd.ovf     = ovf_r;
    unique case (state_r)
      ST_CLR: pk_cmd.op = PK_CLEAR;
      ST_PUT: if (pk_ready) begin
        pk_cmd.op = PK_PUT;
      end
      ST_FOLW: if (pk_ready && pend_r != '0) begin
        pk_cmd.op      = PK_PUT;
        pk_cmd.bit_val = !bit_r;
      end
      ST_FLUSH: if (pk_ready) begin
        pk_cmd.op = PK_FLUSH;
      end
      ST_FIN: if (pk_ready) begin
        pk_cmd.op = PK_FINISH;
      end
      default: pk_cmd.op = PK_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      idx_r       <= '0;
      max_total_r <= MAX_TOT_RST;
    end else begin
      if (cfg_valid) begin
        max_total_r <= cfg_max_total;
      end
      unique case (state_r)
        ST_CLR: begin
          lo_r   <= '0;
          hi_r   <= TOP_VAL;
          pend_r <= '0;
          ovf_r  <= 1'b0;
          if (idx_r == LAST_IDX) begin
            state_r <= ST_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_IDLE: if (in_valid) begin
          sym_r   <= in_end_of_stream ? LAST_IDX : {1'b0, in_byte_in} + 1'b1;
          eof_r   <= in_end_of_stream;
          final_r <= 1'b0;
          state_r <= ST_RD1;
        end
        ST_RD1: begin
          total_r <= rdata;
          state_r <= ST_RD2;
        end
        ST_RD2: begin
          ca_r    <= rdata;
          state_r <= ST_RD3;
        end
        ST_RD3: begin
          cb_r    <= rdata;
          prod_r  <= rng * ca_r;
          state_r <= ST_DIVA;
        end
        ST_DIVA: state_r <= ST_WTA;
        ST_WTA: if (div_done) begin
          hi_tmp_r <= lo_r + quo[CODE_W-1:0] - 1'b1;
          prod_r   <= rng * cb_r;
          state_r  <= ST_DIVB;
        end
        ST_DIVB: state_r <= ST_WTB;
        ST_WTB: if (div_done) begin
          lo_r    <= lo_r + quo[CODE_W-1:0];
          hi_r    <= hi_tmp_r;
          n_r     <= '0;
          state_r <= ST_TEST;
        end
        ST_TEST: begin
          if (n_r == RN_LIMIT) begin
            state_r <= ST_AFT;
          end else if (hi_r < HALF_PT) begin
            bit_r   <= 1'b0;
            lo_r    <= lo_r << 1;
            hi_r    <= (hi_r << 1) | CODE_W'(1);
            n_r     <= n_r + 1'b1;
            state_r <= ST_PUT;
          end else if (lo_r >= HALF_PT) begin
            bit_r   <= 1'b1;
            lo_r    <= (lo_r - HALF_PT) << 1;
            hi_r    <= ((hi_r - HALF_PT) << 1) | CODE_W'(1);
            n_r     <= n_r + 1'b1;
            state_r <= ST_PUT;
          end else if (lo_r >= QTR_1 && hi_r < QTR_3) begin
            if (pend_r >= FOLLOW_MAX) begin
              ovf_r <= 1'b1;
            end else begin
              pend_r <= pend_r + 1'b1;
            end
            lo_r <= (lo_r - QTR_1) << 1;
            hi_r <= ((hi_r - QTR_1) << 1) | CODE_W'(1);
            n_r  <= n_r + 1'b1;
          end else begin
            state_r <= ST_AFT;
          end
        end
        ST_AFT: begin
          if (eof_r) begin
            // Final bit picks the quarter that the interval still covers.
            if (pend_r >= FOLLOW_MAX) begin
              ovf_r <= 1'b1;
            end else begin
              pend_r <= pend_r + 1'b1;
            end
            bit_r   <= (lo_r >= QTR_1);
            final_r <= 1'b1;
            state_r <= ST_PUT;
          end else begin
            state_r <= ST_ADP;
          end
        end
        ST_PUT: if (pk_ready) begin
          state_r <= ST_FOLW;
        end
        ST_FOLW: begin
          if (pend_r == '0) begin
            state_r <= final_r ? ST_FLUSH : ST_TEST;
          end else if (pk_ready) begin
            pend_r <= pend_r - 1'b1;
          end
        end
        ST_FLUSH: if (pk_ready) begin
          state_r <= ST_FIN;
        end
        ST_ADP: state_r <= (total_r >= max_total_r) ? ST_HV0 : ST_INC0;
        ST_HV0: state_r <= ST_HV1;
        ST_HV1: begin
          ob_r    <= rdata;
          nbw_r   <= rdata;
          idx_r   <= LAST_IDX;
          state_r <= ST_HVC;
        end
        ST_HVC: begin
          // Rebuild the table from the top down, one entry per cycle.
          ob_r  <= rdata;
          nbw_r <= hv_new;
          idx_r <= idx_r - 1'b1;
          if (idx_r == ADDR_W'(1)) begin
            state_r <= ST_INC0;
          end
        end
        ST_INC0: begin
          idx_r   <= '0;
          state_r <= ST_INC1;
        end
        ST_INC1: begin
          if (idx_r == sym_r - 1'b1) begin
            state_r <= ST_FIN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_FIN: if (pk_ready) begin
          idx_r   <= '0;
          state_r <= eof_r ? ST_CLR : ST_IDLE;
        end
        default: state_r <= ST_CLR;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aae_chk.sv =====
// Port-level checks for the adaptive arithmetic encoder, bound to the top.
// Depends on adaptive_arithmetic_encoder's port list only.
`default_nettype none
module aae_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_last_of_run
);

  // A result word that is held back must stay, unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(out_last_of_run))
    else $error("stalled result word changed");

  // The block works on one word at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in work");

  // The count table is rewritten after reset before any word is taken.
  assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input open right after reset");

endmodule

bind adaptive_arithmetic_encoder aae_chk u_aae_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run)
);
`default_nettype wire
